>>> rtl/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants, register codes and helpers for the streaming 2-D max
// pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2d_pkg;

   // Default sizing of the block.
   localparam int unsigned MP2D_MAX_KERNEL   = 8;
   localparam int unsigned MP2D_MAX_WIDTH    = 1024;
   localparam int unsigned MP2D_MAX_HEIGHT   = 1024;
   localparam int unsigned MP2D_MAX_CHANNELS = 4;
   localparam int unsigned MP2D_SAMPLE_BITS  = 16;

   // Control port geometry.
   localparam int unsigned CFG_INDEX_BITS = 3;
   localparam int unsigned CFG_DATA_BITS  = 11;

   // Stride and the phase counters that follow it.
   localparam int unsigned STRIDE_BITS = 4;
   localparam int unsigned STRIDE_MAX  = 8;
   localparam int unsigned PHASE_BITS  = 3;

   // Register values after reset, before clamping.
   localparam int unsigned KERNEL_RESET   = 3;
   localparam int unsigned STRIDE_RESET   = 1;
   localparam int unsigned WIDTH_RESET    = 120;
   localparam int unsigned HEIGHT_RESET   = 100;
   localparam int unsigned CHANNELS_RESET = 3;

   // Register indexes on the control port.
   typedef enum logic [CFG_INDEX_BITS-1:0] {
      REG_KERNEL   = 3'd0,
      REG_STRIDE   = 3'd1,
      REG_WIDTH    = 3'd2,
      REG_HEIGHT   = 3'd3,
      REG_CHANNELS = 3'd4
   } cfg_reg_type;

   // A written zero acts as one; values above the bound saturate to it.
   function automatic int unsigned clamp_reg(input int unsigned value,
                                             input int unsigned high);
      int unsigned result;
      if (value == 0) begin
         result = 1;
      end else if (value > high) begin
         result = high;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

>>> rtl/max_pool_2d_valid_top.sv
// ----------------------------------------------------------------------------
// max_pool_2d_valid_top
// Streaming 2-D max pooling with VALID padding over an interleaved image.
// ----------------------------------------------------------------------------
// Samples arrive in raster order (row, column, channel innermost) and one
// sample is accepted every cycle while req_tready is high. Each sample
// leaves at most one pooled value, which passes the stage 1, stage 2
// and output registers; rsp_tlast marks the last pooled value of a frame.
// The line store is one bank per row slot (MAX_KERNEL banks, each
// MAX_WIDTH*MAX_CHANNELS deep) with one write and one read port; all banks
// are read in parallel in the accept cycle, so the line store sets no limit
// below one item per cycle. The store needs no clearing pass after reset:
// an entry is only read after it was written in the same frame. A write to a
// defined register restarts the frame. Configure only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_valid_top #(
   parameter int unsigned MAX_KERNEL   = mp2d_pkg::MP2D_MAX_KERNEL,
   parameter int unsigned MAX_WIDTH    = mp2d_pkg::MP2D_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT   = mp2d_pkg::MP2D_MAX_HEIGHT,
   parameter int unsigned MAX_CHANNELS = mp2d_pkg::MP2D_MAX_CHANNELS,
   parameter int unsigned SAMPLE_BITS  = mp2d_pkg::MP2D_SAMPLE_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Sample stream.
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,  // sample
   // Pooled stream.
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]            rsp_tdata,  // pooled
   output logic                                        rsp_tlast,  // frame_done
   // Control registers.
   input  wire logic                                   csr_wr_en,
   input  wire logic [mp2d_pkg::CFG_INDEX_BITS-1:0]    csr_index,
   input  wire logic [mp2d_pkg::CFG_DATA_BITS-1:0]     csr_wdata
);
   import mp2d_pkg::*;

   localparam int unsigned DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int unsigned K_BITS     = $clog2(MAX_KERNEL + 1);
   localparam int unsigned W_BITS     = $clog2(MAX_WIDTH + 1);
   localparam int unsigned H_BITS     = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned N_BITS     = $clog2(MAX_CHANNELS + 1);
   localparam int unsigned R_BITS     = $clog2(MAX_HEIGHT);
   localparam int unsigned C_BITS     = $clog2(MAX_WIDTH);
   localparam int unsigned CH_BITS    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned SLOT_BITS  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int unsigned LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int unsigned ADDR_BITS  = $clog2(LINE_DEPTH);
   localparam int unsigned TAPS       = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

   // Effective (clamped) configuration.
   logic [K_BITS-1:0]      kernel_ff;
   logic [STRIDE_BITS-1:0] stride_ff;
   logic [W_BITS-1:0]      width_ff;
   logic [H_BITS-1:0]      height_ff;
   logic [N_BITS-1:0]      channels_ff;
   logic                   cfg_hit;

   // Frame position counters.
   logic [R_BITS-1:0]      row_ff, row_in;
   logic [C_BITS-1:0]      col_ff, col_in;
   logic [CH_BITS-1:0]     chan_ff, chan_in;
   logic [PHASE_BITS-1:0]  row_phase_ff, row_phase_in;
   logic [PHASE_BITS-1:0]  col_phase_ff, col_phase_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;

   // Handshake and flow control.
   logic accept;
   logic out_free;
   logic s2_leave;
   logic s2_free;
   logic s1_free;

   // Accept-cycle decode.
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [ADDR_BITS-1:0]          line_addr;
   logic [MAX_KERNEL-1:0]         bank_mask;
   logic                          row_full;
   logic                          emit;
   logic                          last;

   // Stage 1: sample plus the line store read data.
   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [CH_BITS-1:0]            s1_chan_ff;
   logic [MAX_KERNEL-1:0]         s1_mask_ff;
   logic                          s1_emit_ff;
   logic                          s1_last_ff;
   logic signed [SAMPLE_BITS-1:0] line_rd_ff [MAX_KERNEL];
   logic signed [SAMPLE_BITS-1:0] col_max;

   // Stage 2: column maximum and the window over earlier columns.
   logic                          s2_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s2_colmax_ff;
   logic [CH_BITS-1:0]            s2_chan_ff;
   logic                          s2_emit_ff;
   logic                          s2_last_ff;
   logic signed [SAMPLE_BITS-1:0] win_ff [MAX_CHANNELS][TAPS];
   logic signed [SAMPLE_BITS-1:0] win_max;

   // Result register.
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_pooled_ff;
   logic                          rsp_last_ff;

   // ------------------------------------------------------------------------
   // Configuration registers, clamped as they are written.
   // ------------------------------------------------------------------------
   always_comb begin
      case (csr_index)
         REG_KERNEL, REG_STRIDE, REG_WIDTH, REG_HEIGHT, REG_CHANNELS: cfg_hit = csr_wr_en;
         default: cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff   <= K_BITS'(clamp_reg(KERNEL_RESET, MAX_KERNEL));
         stride_ff   <= STRIDE_BITS'(clamp_reg(STRIDE_RESET, STRIDE_MAX));
         width_ff    <= W_BITS'(clamp_reg(WIDTH_RESET, MAX_WIDTH));
         height_ff   <= H_BITS'(clamp_reg(HEIGHT_RESET, MAX_HEIGHT));
         channels_ff <= N_BITS'(clamp_reg(CHANNELS_RESET, MAX_CHANNELS));
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_KERNEL: begin
               kernel_ff <= K_BITS'(clamp_reg(32'(csr_wdata[3:0]), MAX_KERNEL));
            end
            REG_STRIDE: begin
               stride_ff <= STRIDE_BITS'(clamp_reg(32'(csr_wdata[3:0]), STRIDE_MAX));
            end
            REG_WIDTH: begin
               width_ff <= W_BITS'(clamp_reg(32'(csr_wdata), MAX_WIDTH));
            end
            REG_HEIGHT: begin
               height_ff <= H_BITS'(clamp_reg(32'(csr_wdata), MAX_HEIGHT));
            end
            REG_CHANNELS: begin
               channels_ff <= N_BITS'(clamp_reg(32'(csr_wdata[2:0]), MAX_CHANNELS));
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Flow control: each stage moves when the one after it frees up.
   // Items that leave no result drop out of stage 2 without the output.
   // ------------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_leave   = !s2_emit_ff || out_free;
   assign s2_free    = !s2_valid_ff || s2_leave;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign accept     = req_tvalid && s1_free;

   // ------------------------------------------------------------------------
   // Accept-cycle decode: window position, result flags and bank selection.
   // ------------------------------------------------------------------------
   assign sample    = req_tdata[SAMPLE_BITS-1:0];
   assign line_addr = ADDR_BITS'(col_ff) * ADDR_BITS'(MAX_CHANNELS) + ADDR_BITS'(chan_ff);
   assign row_full  = (32'(row_ff) + 32'd1) >= 32'(kernel_ff);
   assign emit      = row_full && ((32'(col_ff) + 32'd1) >= 32'(kernel_ff))
                      && (row_phase_ff == '0) && (col_phase_ff == '0);
   // The last window in a direction is the aligned one with no room for a step.
   assign last      = emit
                      && ((32'(row_ff) + 32'(stride_ff)) >= 32'(height_ff))
                      && ((32'(col_ff) + 32'(stride_ff)) >= 32'(width_ff))
                      && ((32'(chan_ff) + 32'd1) == 32'(channels_ff));

   // A bank takes part when it holds one of the kernel-1 rows above this one.
   always_comb begin
      int unsigned row_gap;
      for (int b = 0; b < MAX_KERNEL; b++) begin
         if (32'(slot_ff) >= 32'(b)) begin
            row_gap = 32'(slot_ff) - 32'(b);
         end else begin
            row_gap = 32'(slot_ff) + MAX_KERNEL - 32'(b);
         end
         bank_mask[b] = (row_gap != 0) && (row_gap < 32'(kernel_ff));
      end
   end

   // ------------------------------------------------------------------------
   // Position counters: channel, then column, then row, with the stride
   // phases counting once a full window fits in that direction.
   // ------------------------------------------------------------------------
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      chan_in      = chan_ff;
      row_phase_in = row_phase_ff;
      col_phase_in = col_phase_ff;
      slot_in      = slot_ff;
      if (cfg_hit) begin
         row_in       = '0;
         col_in       = '0;
         chan_in      = '0;
         row_phase_in = '0;
         col_phase_in = '0;
         slot_in      = '0;
      end else if (accept) begin
         if ((32'(chan_ff) + 32'd1) >= 32'(channels_ff)) begin
            chan_in = '0;
            if ((32'(col_ff) + 32'd1) >= 32'(kernel_ff)) begin
               if ((32'(col_phase_ff) + 32'd1) >= 32'(stride_ff)) begin
                  col_phase_in = '0;
               end else begin
                  col_phase_in = col_phase_ff + PHASE_BITS'(1);
               end
            end
            if ((32'(col_ff) + 32'd1) >= 32'(width_ff)) begin
               col_in       = '0;
               col_phase_in = '0;
               if (row_full) begin
                  if ((32'(row_phase_ff) + 32'd1) >= 32'(stride_ff)) begin
                     row_phase_in = '0;
                  end else begin
                     row_phase_in = row_phase_ff + PHASE_BITS'(1);
                  end
               end
               if ((32'(slot_ff) + 32'd1) >= MAX_KERNEL) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + SLOT_BITS'(1);
               end
               if ((32'(row_ff) + 32'd1) >= 32'(height_ff)) begin
                  row_in       = '0;
                  row_phase_in = '0;
                  slot_in      = '0;
               end else begin
                  row_in = row_ff + R_BITS'(1);
               end
            end else begin
               col_in = col_ff + C_BITS'(1);
            end
         end else begin
            chan_in = chan_ff + CH_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         chan_ff      <= '0;
         row_phase_ff <= '0;
         col_phase_ff <= '0;
         slot_ff      <= '0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         chan_ff      <= chan_in;
         row_phase_ff <= row_phase_in;
         col_phase_ff <= col_phase_in;
         slot_ff      <= slot_in;
      end
   end

   // ------------------------------------------------------------------------
   // Line store: one bank per row slot. The current row is written into its
   // slot while every bank is read at the same column and channel.
   // ------------------------------------------------------------------------
   for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
      logic [SAMPLE_BITS-1:0] mem [LINE_DEPTH];

      always_ff @(posedge clock) begin
         if (accept) begin
            if (slot_ff == SLOT_BITS'(b)) begin
               mem[line_addr] <= sample;
            end
            line_rd_ff[b] <= mem[line_addr];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1 register.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= sample;
         s1_chan_ff   <= chan_ff;
         s1_mask_ff   <= bank_mask;
         s1_emit_ff   <= emit;
         s1_last_ff   <= last;
      end
   end

   // Column maximum over the sample and the rows above it.
   always_comb begin
      col_max = s1_sample_ff;
      for (int b = 0; b < MAX_KERNEL; b++) begin
         if (s1_mask_ff[b] && (line_rd_ff[b] > col_max)) begin
            col_max = line_rd_ff[b];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2 register.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_colmax_ff <= col_max;
         s2_chan_ff   <= s1_chan_ff;
         s2_emit_ff   <= s1_emit_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // Window maximum over this column and the kernel-1 columns before it.
   always_comb begin
      win_max = s2_colmax_ff;
      for (int t = 0; t < TAPS; t++) begin
         if (((t + 1) < int'(kernel_ff)) && (win_ff[s2_chan_ff][t] > win_max)) begin
            win_max = win_ff[s2_chan_ff][t];
         end
      end
   end

   // Per-channel column window: shifts in each column maximum as it leaves.
   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_leave) begin
         for (int t = TAPS - 1; t > 0; t--) begin
            win_ff[s2_chan_ff][t] <= win_ff[s2_chan_ff][t-1];
         end
         win_ff[s2_chan_ff][0] <= s2_colmax_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff && s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff && s2_emit_ff) begin
         rsp_pooled_ff <= win_max;
         rsp_last_ff   <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(unsigned'(rsp_pooled_ff));
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> tb/tb_max_pool_2d_valid_top.sv
// ----------------------------------------------------------------------------
// tb_max_pool_2d_valid_top
// Self-checking bench for the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
// Samples are fed in raster order under a number of register settings. A
// scoreboard keeps its own line store, column maxima and window phases,
// works out the pooled value and frame flag that each sample should
// produce, and checks every pooled item that leaves the block in order.
// The feed runs in bursts with gaps. The output side stalls on patterns of
// its own, with one long hold-off that backs the block up. Settings include
// out-of-range register values and a kernel larger than the frame.
// ----------------------------------------------------------------------------

module tb_max_pool_2d_valid_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mp2d_pkg::*;

   localparam int unsigned DATA_W        = ((MP2D_SAMPLE_BITS + 7) / 8) * 8;
   localparam int unsigned LINE_DEPTH    = MP2D_MAX_KERNEL * MP2D_MAX_WIDTH
                                           * MP2D_MAX_CHANNELS;
   localparam int unsigned WINDOW_DEPTH  = MP2D_MAX_KERNEL * MP2D_MAX_CHANNELS;
   localparam int unsigned RANDOM_ITEMS  = 700;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned REPORT_LIMIT  = 30;
   localparam logic [4:0]  ALL_REGS      = 5'b11111;
   localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_LOW  = REG_CHANNELS + 1'b1;
   localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_HIGH = '1;

   typedef logic signed [MP2D_SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(MP2D_SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(MP2D_SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [MP2D_SAMPLE_BITS-1:0] pooled;
      logic                        frame_done;
   } pooled_item_type;

   // Scoreboard: register copies, window state and the expected pooled items.
   class pool_scoreboard_type;
      bit [3:0]             kernel_reg;
      bit [STRIDE_BITS-1:0] stride_reg;
      bit [10:0]            width_reg;
      bit [10:0]            height_reg;
      bit [2:0]             channel_reg;
      bit [9:0]             row_pos;
      bit [9:0]             col_pos;
      bit [1:0]             chan_pos;
      bit [PHASE_BITS-1:0]  row_phase;
      bit [PHASE_BITS-1:0]  col_phase;
      sample_type           line_rows [LINE_DEPTH];
      sample_type           col_max [WINDOW_DEPTH];
      pooled_item_type      expected_pooled [$];
      int unsigned          mismatches;
      int unsigned          pooled_checked;
      int unsigned          frames_closed;
      int unsigned          samples_seen;

      function new();
         kernel_reg  = 4'(KERNEL_RESET);
         stride_reg  = STRIDE_BITS'(STRIDE_RESET);
         width_reg   = 11'(WIDTH_RESET);
         height_reg  = 11'(HEIGHT_RESET);
         channel_reg = 3'(CHANNELS_RESET);
         restart_frame();
      endfunction

      // Zero behaves as one and anything above the bound saturates.
      static function int unsigned effective(int unsigned raw, int unsigned high);
         int unsigned value;
         value = raw;
         if (value == 0) value = 1;
         if (value > high) value = high;
         return value;
      endfunction

      function void restart_frame();
         row_pos   = '0;
         col_pos   = '0;
         chan_pos  = '0;
         row_phase = '0;
         col_phase = '0;
      endfunction

      function int unsigned frame_samples();
         return effective(width_reg, MP2D_MAX_WIDTH)
                * effective(height_reg, MP2D_MAX_HEIGHT)
                * effective(channel_reg, MP2D_MAX_CHANNELS);
      endfunction

      // Writes to a spare index are ignored and leave the frame where it is.
      function void note_register(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] data);
         case (index)
            REG_KERNEL:   kernel_reg  = data[3:0];
            REG_STRIDE:   stride_reg  = data[STRIDE_BITS-1:0];
            REG_WIDTH:    width_reg   = data;
            REG_HEIGHT:   height_reg  = data;
            REG_CHANNELS: channel_reg = data[2:0];
            default:      return;
         endcase
         restart_frame();
      endfunction

      function int unsigned line_slot(int unsigned row, int unsigned col,
                                      int unsigned chan);
         return ((row % MP2D_MAX_KERNEL) * MP2D_MAX_WIDTH + col)
                * MP2D_MAX_CHANNELS + chan;
      endfunction

      function int unsigned window_slot(int unsigned col, int unsigned chan);
         return (col % MP2D_MAX_KERNEL) * MP2D_MAX_CHANNELS + chan;
      endfunction

      // Takes one accepted sample and queues the pooled item it completes.
      function void pool_sample(sample_type value);
         int unsigned     k, s, w, h, nch, r, c, ch, i, last_r, last_c;
         sample_type      column_top, best;
         pooled_item_type item;
         k   = effective(kernel_reg, MP2D_MAX_KERNEL);
         s   = effective(stride_reg, STRIDE_MAX);
         w   = effective(width_reg, MP2D_MAX_WIDTH);
         h   = effective(height_reg, MP2D_MAX_HEIGHT);
         nch = effective(channel_reg, MP2D_MAX_CHANNELS);
         r   = row_pos;
         c   = col_pos;
         ch  = chan_pos;
         samples_seen++;

         // Column maximum over the rows of the window, then across columns.
         if (r >= k - 1) begin
            column_top = value;
            for (i = 1; i < k; i++) begin
               if (line_rows[line_slot(r - i, c, ch)] > column_top) begin
                  column_top = line_rows[line_slot(r - i, c, ch)];
               end
            end
            col_max[window_slot(c, ch)] = column_top;
            if (c >= k - 1 && row_phase == 0 && col_phase == 0) begin
               best = column_top;
               for (i = 1; i < k; i++) begin
                  if (col_max[window_slot(c - i, ch)] > best) begin
                     best = col_max[window_slot(c - i, ch)];
                  end
               end
               last_r = (k - 1) + s * ((h - k) / s);
               last_c = (k - 1) + s * ((w - k) / s);
               item.pooled     = best;
               item.frame_done = (r == last_r) && (c == last_c) && (ch == nch - 1);
               expected_pooled = {expected_pooled, item};
            end
         end
         line_rows[line_slot(r, c, ch)] = value;

         // Step through channel, column and row; phases count only once the
         // window fits in that direction.
         ch++;
         if (ch >= nch) begin
            ch = 0;
            if (c >= k - 1) begin
               col_phase = (col_phase + 1 >= s) ? '0 : col_phase + 1'b1;
            end
            c++;
            if (c >= w) begin
               c = 0;
               col_phase = '0;
               if (r >= k - 1) begin
                  row_phase = (row_phase + 1 >= s) ? '0 : row_phase + 1'b1;
               end
               r++;
               if (r >= h) begin
                  r = 0;
                  row_phase = '0;
               end
            end
         end
         row_pos  = r[9:0];
         col_pos  = c[9:0];
         chan_pos = ch[1:0];
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
         end
      endtask

      // Compares one pooled item with the oldest one still expected.
      task check_pooled(logic [MP2D_SAMPLE_BITS-1:0] pooled, logic frame_done);
         pooled_item_type want;
         if (expected_pooled.size() == 0) begin
            report_mismatch($sformatf("pooled %h (last %b) with nothing expected",
                                      pooled, frame_done));
         end else begin
            want = expected_pooled.pop_front();
            pooled_checked++;
            if (want.frame_done) frames_closed++;
            if (pooled !== want.pooled) begin
               report_mismatch($sformatf("pooled %h, expected %h", pooled, want.pooled));
            end
            if (frame_done !== want.frame_done) begin
               report_mismatch($sformatf("frame end flag %b, expected %b",
                                         frame_done, want.frame_done));
            end
         end
      endtask
   endclass

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DATA_W-1:0]         req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [DATA_W-1:0]         rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_wr_en  = 1'b0;
   logic [CFG_INDEX_BITS-1:0] csr_index  = '0;
   logic [CFG_DATA_BITS-1:0]  csr_wdata  = '0;

   pool_scoreboard_type pool_check = new();
   int unsigned    cycles          = 0;
   int unsigned    hold_requests   = 0;
   int unsigned    burst_left      = 0;
   bit             steady_feed     = 1'b0;
   int unsigned    settings_count  = 0;

   max_pool_2d_valid_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run limit of %0d cycles reached, %0d pooled items still owed.",
                  CYCLE_LIMIT, pool_check.expected_pooled.size());
         $display("** max_pool_2d_valid_top: FAILED **");
         $finish;
      end
   end

   // Every accepted pooled item goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         pool_check.check_pooled(rsp_tdata[MP2D_SAMPLE_BITS-1:0], rsp_tlast);
      end
   end

   // Output side: ready follows a rotating pattern that changes now and then;
   // each requested hold-off keeps it low for a counted stretch.
   initial begin : output_pacing
      int unsigned   span, n, holds_served;
      logic [15:0]   pattern;
      holds_served = 0;
      forever begin
         pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         span    = $urandom_range(16, 160);
         for (n = 0; n < span; n++) begin
            @(posedge clock);
            if (hold_requests != holds_served) begin
               holds_served = hold_requests;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            rsp_tready <= pattern[n % 16];
         end
      end
   end

   // Mostly ordinary values, with the signed extremes, values near zero
   // and all-negative ones mixed in.
   function automatic sample_type pick_sample();
      sample_type value;
      case ($urandom_range(0, 9))
         0:       value = SAMPLE_MAX;
         1:       value = SAMPLE_MIN;
         2:       value = sample_type'(int'($urandom_range(0, 16)) - 8);
         3, 4:    value = sample_type'($urandom) | SAMPLE_MIN;
         default: value = sample_type'($urandom);
      endcase
      return value;
   endfunction

   // Narrow registers sometimes get random bits above their width.
   function automatic logic [CFG_DATA_BITS-1:0] with_junk(int unsigned value,
                                                          int unsigned bits);
      logic [CFG_DATA_BITS-1:0] data;
      data = CFG_DATA_BITS'(value);
      if ($urandom_range(0, 1) == 0) begin
         data = data | CFG_DATA_BITS'($urandom << bits);
      end
      return data;
   endfunction

   // Offers one sample, opening a gap first when a burst has run out.
   task automatic offer_sample(input sample_type value);
      int unsigned gap;
      if (!steady_feed && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(value);
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      pool_check.pool_sample(value);
   endtask

   task automatic send_random(input int unsigned count);
      int unsigned n;
      for (n = 0; n < count; n++) begin
         offer_sample(pick_sample());
      end
   endtask

   // Stops the feed and waits for the block to go quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pool_check.expected_pooled.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                            input logic [CFG_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      pool_check.note_register(index, data);
   endtask

   task automatic apply_settings(input int unsigned kernel,
                                 input int unsigned stride,
                                 input int unsigned width,
                                 input int unsigned height,
                                 input int unsigned channels,
                                 input logic [4:0] which);
      if (which[REG_KERNEL])   write_reg(REG_KERNEL, CFG_DATA_BITS'(kernel));
      if (which[REG_STRIDE])   write_reg(REG_STRIDE, CFG_DATA_BITS'(stride));
      if (which[REG_WIDTH])    write_reg(REG_WIDTH, CFG_DATA_BITS'(width));
      if (which[REG_HEIGHT])   write_reg(REG_HEIGHT, CFG_DATA_BITS'(height));
      if (which[REG_CHANNELS]) write_reg(REG_CHANNELS, CFG_DATA_BITS'(channels));
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   initial begin : stimulus
      int unsigned               random_items, count, first_part, frame;
      int unsigned               kernel, stride, width, height, channels;
      logic [4:0]                which;
      random_items = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // 2x2 windows over a 3x2 frame with the signed extremes, then the
      // start of the next frame.
      apply_settings(2, 1, 3, 2, 1, ALL_REGS);
      offer_sample(SAMPLE_MAX);
      offer_sample(SAMPLE_MIN);
      offer_sample(sample_type'(-1));
      offer_sample(SAMPLE_MIN);
      offer_sample('0);
      offer_sample(SAMPLE_MIN);
      offer_sample(sample_type'(16'h5555));
      offer_sample(sample_type'(16'hAAAA));
      settle();

      // All registers zero act as one: every sample closes a frame.
      apply_settings(0, 0, 0, 0, 0, ALL_REGS);
      offer_sample(SAMPLE_MIN);
      offer_sample(sample_type'(-1));
      offer_sample(sample_type'(1));
      settle();

      // Kernel larger than the frame never produces anything.
      apply_settings(4, 2, 3, 3, 1, ALL_REGS);
      send_random(9);
      settle();

      // Kernel and stride far above range saturate to their bounds.
      apply_settings('1, '1, 8, 8, 1, ALL_REGS);
      send_random(64);
      settle();

      // Channel count above range saturates to four.
      apply_settings(1, 1, 2, 1, '1, ALL_REGS);
      send_random(8);
      settle();

      // Long output hold-off while the feed keeps offering samples.
      apply_settings(1, 1, 8, 8, 1, ALL_REGS);
      steady_feed = 1'b1;
      hold_requests++;
      send_random(64);
      steady_feed = 1'b0;
      settle();

      // Random settings, mostly small frames, often stopping mid-frame.
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       kernel = 0;
            1:       kernel = $urandom_range(9, 15);
            2:       kernel = $urandom_range(6, 8);
            default: kernel = $urandom_range(1, 5);
         endcase
         stride   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                : $urandom_range(0, 4);
         width    = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16)
                                                : $urandom_range(1, 8);
         height   = $urandom_range(1, 8);
         channels = $urandom_range(0, 7);
         which    = 5'($urandom);
         if (which == '0) which = ALL_REGS;
         apply_settings(with_junk(kernel, 4), with_junk(stride, STRIDE_BITS),
                        width, height, with_junk(channels, 3), which);

         frame = pool_check.frame_samples();
         count = $urandom_range(frame / 2 + 1, frame * 2 + 1);
         if (count > 300) count = $urandom_range(150, 300);
         steady_feed = ($urandom_range(0, 3) == 0);

         // Sometimes a spare register index is written partway through;
         // the frame must carry on from where it stopped.
         if ($urandom_range(0, 4) == 0) begin
            first_part = $urandom_range(1, count);
            send_random(first_part);
            settle();
            write_reg(CFG_INDEX_BITS'($urandom_range(SPARE_INDEX_LOW, SPARE_INDEX_HIGH)),
                      CFG_DATA_BITS'($urandom));
            csr_wr_en <= 1'b0;
            send_random(count - first_part);
         end else begin
            send_random(count);
         end
         steady_feed   = 1'b0;
         random_items += count;
         settle();
      end

      $display("Fed %0d samples under %0d register settings; %0d pooled items checked,",
               pool_check.samples_seen, settings_count, pool_check.pooled_checked);
      $display("%0d frames closed, including saturated registers and a %0d-cycle output hold.",
               pool_check.frames_closed, HOLD_CYCLES);
      if (pool_check.mismatches == 0) begin
         $display("** max_pool_2d_valid_top: PASSED **");
      end else begin
         $display("%0d mismatches found.", pool_check.mismatches);
         $display("** max_pool_2d_valid_top: FAILED **");
      end
      $finish;
   end

endmodule
